FILE: design/sfd_pkg.sv
// Shared types and constants for the sensor frame deframer.
// No dependencies; imported by sfd_collect, sfd_decode, the core and the testbench.
package sfd_pkg;

    localparam int FRAME_LEN = 4 + 3 + 1 + 1;

    localparam logic [3:0] POS_NEED  = 4'd9;
    localparam logic [3:0] PROF_NEED = 4'd2;
    localparam logic [3:0] CNT_MAX   = 4'd15;

    localparam logic [7:0] SYNC_B = 8'h42;
    localparam logic [7:0] SYNC_Z = 8'h5A;

    localparam logic [31:0] ANGLE_ZERO = 32'h4000_0000;
    localparam logic [25:0] X_ZERO     = 26'h040_0000;

    localparam logic [1:0] MODE_POSITION = 2'd0;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    localparam logic CFG_DEVICE_MODE = 1'b0;
    localparam logic CFG_TIP_HOLD    = 1'b1;

    typedef logic [FRAME_LEN-1:0][7:0] t_frame_bytes;

    typedef struct packed {
        logic vld;
        logic position;
        logic hold;
    } t_done;

endpackage

FILE: design/sfd_collect.sv
// Sync hunt and frame byte capture for the sensor frame deframer.
// Depends on sfd_pkg.
module sfd_collect (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    input  logic [1:0]           i_mode,
    input  logic                 i_tip_hold,
    input  logic                 i_take,
    output sfd_pkg::t_done       o_done,
    output sfd_pkg::t_frame_bytes o_bytes
);
    import sfd_pkg::*;

    logic         r_in_frame;
    logic [3:0]   r_cnt;
    t_done        r_done;
    t_frame_bytes r_bytes;

    logic         n_in_frame;
    logic [3:0]   n_cnt;
    t_done        n_done;
    logic         position;
    logic         store_en;
    logic [3:0]   cnt_inc;
    logic [3:0]   need;

    assign position = (i_mode == MODE_POSITION);
    assign cnt_inc  = (r_cnt < CNT_MAX) ? r_cnt + 4'd1 : r_cnt;
    assign need     = position ? POS_NEED : PROF_NEED;
    assign store_en = i_accept && r_in_frame && (i_mode != MODE_UNUSED);

    always_comb begin
        n_in_frame = r_in_frame;
        n_cnt      = r_cnt;
        n_done     = r_done;
        if (i_take) begin
            n_done.vld = 1'b0;
        end
        if (i_accept) begin
            if (i_mode == MODE_UNUSED) begin
                n_in_frame = 1'b0;
                n_cnt      = 4'd0;
            end else if (!r_in_frame) begin
                if (i_rx_byte == SYNC_B || (!position && i_rx_byte == SYNC_Z)) begin
                    n_in_frame = 1'b1;
                    n_cnt      = 4'd0;
                end
            end else if (cnt_inc >= need) begin
                n_in_frame      = 1'b0;
                n_cnt           = 4'd0;
                n_done.vld      = 1'b1;
                n_done.position = position;
                n_done.hold     = i_tip_hold;
            end else begin
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cnt      <= 4'd0;
            r_done     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_cnt      <= n_cnt;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (store_en && r_cnt == 4'(i)) begin
                r_bytes[i] <= i_rx_byte;
            end
        end
    end

    assign o_done  = r_done;
    assign o_bytes = r_bytes;

endmodule

FILE: design/sfd_decode.sv
// Frame decode, frame counter, tip latch and result register.
// Depends on sfd_pkg.
module sfd_decode (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  sfd_pkg::t_done        i_done,
    input  sfd_pkg::t_frame_bytes i_bytes,
    input  logic                  i_out_stall,
    output logic                  o_take,
    output logic                  o_out_valid,
    output logic                  o_frame_kind,
    output logic signed [31:0]    o_angle_count,
    output logic signed [25:0]    o_x_position_nm,
    output logic [7:0]            o_alarm_code,
    output logic [15:0]           o_profile_value,
    output logic [31:0]           o_point_index,
    output logic [31:0]           o_tip_level
);
    import sfd_pkg::*;

    logic        r_out_valid;
    logic [31:0] r_counter;
    logic [31:0] r_tip;
    logic        r_kind;
    logic [31:0] r_angle;
    logic [25:0] r_xnm;
    logic [7:0]  r_alarm;
    logic [15:0] r_prof;
    logic [31:0] r_index;
    logic [31:0] r_tip_out;

    logic [31:0] raw_angle;
    logic [25:0] raw_x;
    logic [31:0] n_tip;

    assign o_take    = i_done.vld && (!r_out_valid || !i_out_stall);
    assign raw_angle = {i_bytes[3], i_bytes[2], i_bytes[1], i_bytes[0]};
    assign raw_x     = {2'b00, i_bytes[6], i_bytes[5], i_bytes[4]};
    assign n_tip     = (i_done.position && !i_done.hold) ? raw_angle : r_tip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_counter   <= 32'd0;
            r_tip       <= 32'd0;
        end else begin
            r_out_valid <= o_take || (r_out_valid && i_out_stall);
            if (o_take) begin
                r_counter <= r_counter + 32'd1;
                r_tip     <= n_tip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_kind    <= !i_done.position;
            r_angle   <= i_done.position ? raw_angle - ANGLE_ZERO : 32'd0;
            r_xnm     <= i_done.position ? (raw_x - X_ZERO) << 1 : 26'd0;
            r_alarm   <= i_done.position ? i_bytes[8] : 8'd0;
            r_prof    <= i_done.position ? 16'd0 : {i_bytes[0], i_bytes[1]};
            r_index   <= r_counter;
            r_tip_out <= n_tip;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_kind    = r_kind;
    assign o_angle_count   = $signed(r_angle);
    assign o_x_position_nm = $signed(r_xnm);
    assign o_alarm_code    = r_alarm;
    assign o_profile_value = r_prof;
    assign o_point_index   = r_index;
    assign o_tip_level     = r_tip_out;

endmodule

FILE: design/sensor_frame_deframer_core.sv
// Sensor frame deframer: sync hunt, frame capture and decode of serial bytes.
// One byte accepted per cycle unless stalled; the last frame byte loads the done flag, then the result register.
// Input stalls only while a decoded frame waits behind a stalled result register.
// Synchronous active-low reset: hunting, counters and tip level cleared; data registers not reset.
// Depends on sfd_pkg, sfd_collect, sfd_decode.
module sensor_frame_deframer_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_frame_kind,
    output logic signed [31:0] o_angle_count,
    output logic signed [25:0] o_x_position_nm,
    output logic [7:0]         o_alarm_code,
    output logic [15:0]        o_profile_value,
    output logic [31:0]        o_point_index,
    output logic [31:0]        o_tip_level
);
    import sfd_pkg::*;

    logic [1:0]   r_mode;
    logic         r_tip_hold;
    t_done        done;
    t_frame_bytes frame;
    logic         take;
    logic         accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_POSITION;
            r_tip_hold <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEVICE_MODE: r_mode     <= i_cfg_data;
                CFG_TIP_HOLD:    r_tip_hold <= i_cfg_data[0];
                default:         r_mode     <= r_mode;
            endcase
        end
    end

    assign o_in_stall = done.vld && !take;
    assign accept     = i_in_valid && !o_in_stall;

    sfd_collect u_collect (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_rx_byte  (i_rx_byte),
        .i_mode     (r_mode),
        .i_tip_hold (r_tip_hold),
        .i_take     (take),
        .o_done     (done),
        .o_bytes    (frame)
    );

    sfd_decode u_decode (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_done          (done),
        .i_bytes         (frame),
        .i_out_stall     (i_out_stall),
        .o_take          (take),
        .o_out_valid     (o_out_valid),
        .o_frame_kind    (o_frame_kind),
        .o_angle_count   (o_angle_count),
        .o_x_position_nm (o_x_position_nm),
        .o_alarm_code    (o_alarm_code),
        .o_profile_value (o_profile_value),
        .o_point_index   (o_point_index),
        .o_tip_level     (o_tip_level)
    );

endmodule

FILE: design/sfd_checker.sv
// Port-level checks for sensor_frame_deframer_core, with its bind.
// No package dependency.
module sfd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_frame_kind,
    input logic signed [31:0] o_angle_count,
    input logic signed [25:0] o_x_position_nm,
    input logic [7:0]         o_alarm_code,
    input logic [15:0]        o_profile_value
);

    // input side backs up only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stall without blocked result");

    a_prof_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_kind) |->
        (o_angle_count == 32'sd0 && o_x_position_nm == 26'sd0 && o_alarm_code == 8'd0))
        else $error("profile transaction carries position fields");

    a_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_frame_kind) |-> (o_profile_value == 16'd0))
        else $error("position transaction carries profile value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_angle_count)))
        else $error("stalled result transaction dropped or changed");

endmodule

bind sensor_frame_deframer_core sfd_checker u_sfd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_frame_kind    (o_frame_kind),
    .o_angle_count   (o_angle_count),
    .o_x_position_nm (o_x_position_nm),
    .o_alarm_code    (o_alarm_code),
    .o_profile_value (o_profile_value)
);

FILE: sim/tb_top.sv
// Self-checking testbench for sensor_frame_deframer_core: directed frames, then random phases.
// Carries its own deframing predictor; depends on sfd_pkg and the core RTL only.
module tb_top;
    import sfd_pkg::*;

    localparam logic [1:0] MODE_PROFILE     = 2'd1;
    localparam logic [1:0] MODE_PROFILE_ALT = 2'd2;
    localparam int LATENCY_WAIT = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int ITEM_TARGET  = 1750;
    localparam int FORCED_ROLL [4] = '{0, 40, 65, 90};

    typedef struct packed {
        logic        kind;
        logic [31:0] angle;
        logic [25:0] x_nm;
        logic [7:0]  alarm;
        logic [15:0] profile;
        logic [31:0] point;
        logic [31:0] tip;
    } t_frame_result;

    typedef struct packed {
        logic          is_cfg;
        logic          reg_sel;
        logic [7:0]    value;
        logic          known;
        t_frame_result want;
    } t_stim_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [1:0]  i_cfg_data  = 2'd0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_rx_byte   = 8'd0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_frame_kind;
    logic signed [31:0] o_angle_count;
    logic signed [25:0] o_x_position_nm;
    logic [7:0]  o_alarm_code;
    logic [15:0] o_profile_value;
    logic [31:0] o_point_index;
    logic [31:0] o_tip_level;

    sensor_frame_deframer_core dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [1:0]  cur_mode    = MODE_POSITION;
    logic        cur_hold    = 1'b0;
    logic        in_frame    = 1'b0;
    logic [3:0]  collected   = 4'd0;
    logic [7:0]  frame_store [FRAME_LEN];
    logic [31:0] frame_count = 32'd0;
    logic [31:0] tip_word    = 32'd0;

    t_frame_result decoded_frames [$];
    int  mismatches   = 0;
    int  cycles       = 0;
    int  stall_left   = 0;
    bit  steady_phase = 1'b0;

    t_stim_row directed_rows [31] = '{
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_Z, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b1,
          '{1'b0, 32'hC000_0000, 26'h380_0000, 8'hFF, 16'h0000, 32'd0, 32'h0000_0000}},
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, 8'hFF, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b0, 1'b0, 8'h00, 1'b1,
          '{1'b0, 32'hBFFF_FFFF, 26'h17F_FFFE, 8'h00, 16'h0000, 32'd1, 32'hFFFF_FFFF}},
        // partial position frame finished under profile mode
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b0, 1'b0, 8'h12, 1'b0, '0},
        '{1'b1, CFG_DEVICE_MODE, {6'd0, MODE_PROFILE}, 1'b0, '0},
        '{1'b1, CFG_TIP_HOLD, 8'd1, 1'b0, '0},
        '{1'b0, 1'b0, 8'h34, 1'b1,
          '{1'b1, 32'h0, 26'h0, 8'h00, 16'h1234, 32'd2, 32'hFFFF_FFFF}},
        '{1'b1, CFG_DEVICE_MODE, {6'd0, MODE_UNUSED}, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b1, CFG_DEVICE_MODE, {6'd0, MODE_PROFILE_ALT}, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_Z, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_B, 1'b0, '0},
        '{1'b0, 1'b0, SYNC_Z, 1'b1,
          '{1'b1, 32'h0, 26'h0, 8'h00, 16'h425A, 32'd3, 32'hFFFF_FFFF}}
    };

    function automatic void deframe_byte(input logic [7:0] rx);
        t_frame_result r;
        logic [3:0]  need;
        logic [31:0] angle_word;
        logic [25:0] x_diff;
        logic        is_pos;
        is_pos = (cur_mode == MODE_POSITION);
        if (cur_mode == MODE_UNUSED) begin
            in_frame  = 1'b0;
            collected = 4'd0;
            return;
        end
        if (!in_frame) begin
            if (rx == SYNC_B || (!is_pos && rx == SYNC_Z)) begin
                in_frame  = 1'b1;
                collected = 4'd0;
            end
            return;
        end
        if (collected < POS_NEED)
            frame_store[collected] = rx;
        if (collected < CNT_MAX)
            collected = collected + 4'd1;
        need = is_pos ? POS_NEED : PROF_NEED;
        if (collected < need)
            return;
        in_frame  = 1'b0;
        collected = 4'd0;
        r = '0;
        if (is_pos) begin
            angle_word = {frame_store[3], frame_store[2], frame_store[1], frame_store[0]};
            x_diff     = {2'b00, frame_store[6], frame_store[5], frame_store[4]} - X_ZERO;
            if (!cur_hold)
                tip_word = angle_word;
            r.angle = angle_word - ANGLE_ZERO;
            r.x_nm  = {x_diff[24:0], 1'b0};
            r.alarm = frame_store[8];
        end else begin
            r.kind    = 1'b1;
            r.profile = {frame_store[0], frame_store[1]};
        end
        r.point = frame_count;
        r.tip   = tip_word;
        frame_count = frame_count + 32'd1;
        decoded_frames.push_back(r);
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady_phase || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_rx_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return SYNC_B;
            3: return SYNC_Z;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void compare_field(input string label, input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    task automatic send_rx(input logic [7:0] rx);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(rx);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (decoded_frames.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic sel, input logic [1:0] data);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (sel == CFG_DEVICE_MODE)
            cur_mode = data;
        else
            cur_hold = data[0];
    endtask

    // result side: check accepted transactions, then pick next stall
    always @(posedge i_clk) begin
        t_frame_result exp_frame;
        int roll;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (decoded_frames.size() == 0) begin
                $display("%0t: unexpected frame, point_index %h", $time, o_point_index);
                mismatches++;
            end else begin
                exp_frame = decoded_frames.pop_front();
                compare_field("frame_kind", exp_frame.kind, o_frame_kind);
                compare_field("angle_count", exp_frame.angle, o_angle_count);
                compare_field("x_position_nm", exp_frame.x_nm, $unsigned(o_x_position_nm));
                compare_field("alarm_code", exp_frame.alarm, o_alarm_code);
                compare_field("profile_value", exp_frame.profile, o_profile_value);
                compare_field("point_index", exp_frame.point, o_point_index);
                compare_field("tip_level", exp_frame.tip, o_tip_level);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (steady_phase || roll < 70)
                stall_left = 0;
            else if (roll < 96)
                stall_left = $urandom_range(1, 3);
            else
                stall_left = $urandom_range(10, 40);
        end
        i_out_stall <= (stall_left > 0);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        int phase;
        int roll;
        int sent;
        int phase_len;
        int body;
        int cut;
        int random_items;
        logic [7:0] sync;
        phase = 0;
        random_items = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[n]) begin
            if (directed_rows[n].is_cfg) begin
                write_reg(directed_rows[n].reg_sel, directed_rows[n].value[1:0]);
            end else begin
                send_rx(directed_rows[n].value);
                if (directed_rows[n].known)
                    decoded_frames[decoded_frames.size() - 1] = directed_rows[n].want;
            end
        end

        while (random_items < ITEM_TARGET) begin
            roll = (phase < 4) ? FORCED_ROLL[phase] : $urandom_range(0, 99);
            if (roll < 40)
                write_reg(CFG_DEVICE_MODE, MODE_POSITION);
            else if (roll < 65)
                write_reg(CFG_DEVICE_MODE, MODE_PROFILE);
            else if (roll < 90)
                write_reg(CFG_DEVICE_MODE, MODE_PROFILE_ALT);
            else
                write_reg(CFG_DEVICE_MODE, MODE_UNUSED);
            write_reg(CFG_TIP_HOLD, (phase < 4) ? phase[1:0] & 2'd1 : 2'($urandom_range(0, 1)));
            steady_phase = ($urandom_range(0, 4) == 0);
            phase_len = (cur_mode == MODE_UNUSED) ? $urandom_range(10, 25)
                                                  : $urandom_range(60, 200);
            body = (cur_mode == MODE_POSITION) ? POS_NEED : PROF_NEED;
            sent = 0;
            while (sent < phase_len) begin
                roll = $urandom_range(0, 99);
                if (roll < 90) begin
                    sync = (cur_mode != MODE_POSITION && $urandom_range(0, 1)) ? SYNC_Z : SYNC_B;
                    // well-formed frame, or a truncated one
                    cut = (roll < 80) ? body : $urandom_range(0, body - 1);
                    send_rx(sync);
                    sent++;
                    for (int k = 0; k < cut && sent < phase_len; k++) begin
                        send_rx(pick_rx_byte());
                        sent++;
                    end
                end else begin
                    send_rx(8'($urandom_range(0, 255)));
                    sent++;
                end
            end
            if (cur_mode != MODE_UNUSED)
                random_items += sent;
            phase++;
        end

        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sensor_frame_deframer_core.f
design/sfd_pkg.sv
design/sfd_collect.sv
design/sfd_decode.sv
design/sensor_frame_deframer_core.sv
design/sfd_checker.sv
sim/tb_top.sv
